// File: sv/lcf_pkg.sv
// ----------------------------------------------------------------------------
// lcf_pkg: shared types and constants for the linear convolution FIR
// Port payload structs, register map, flow control struct and fixed widths.
// ----------------------------------------------------------------------------
package lcf_pkg;

   // fixed field widths
   localparam int SAMPLE_W       = 16;
   localparam int RESULT_W       = 35;
   localparam int COEF_W         = 16;
   localparam int COEFS_PER_WORD = 4;
   localparam int TAP_COUNT_W    = 4;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_LO = 3;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 4'd8;

   // parameter defaults for the top level
   localparam int TAPS_DEFAULT        = 8;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // register index (byte address / 8)
   typedef enum logic [1:0] {
      REG_COEF_LOW  = 2'd0,
      REG_COEF_HIGH = 2'd1,
      REG_TAP_COUNT = 2'd2
   } reg_index_type;

   // input item
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       seq_last;
   } req_type;

   // result item
   typedef struct packed {
      logic signed [RESULT_W-1:0] result;
      logic                       result_last;
   } rsp_type;

   // per-stage flow control
   typedef struct packed {
      logic valid;
      logic last;
   } flow_type;

   // coefficient and tap count registers
   typedef struct packed {
      logic [CSR_DATA_W-1:0]  coef_word_low;
      logic [CSR_DATA_W-1:0]  coef_word_high;
      logic [TAP_COUNT_W-1:0] tap_count;
   } cfg_type;

endpackage

// File: sv/lcf_csr.sv
// ----------------------------------------------------------------------------
// lcf_csr: configuration registers
// APB-style register file holding the two coefficient words and tap count.
// ----------------------------------------------------------------------------
module lcf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lcf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lcf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lcf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output lcf_pkg::cfg_type                  cfg
);

   logic [1:0]            reg_idx;
   logic                  wr_en;
   lcf_pkg::cfg_type      cfg_ff;
   lcf_pkg::cfg_type      cfg_in;

   assign pready  = 1'b1;
   assign reg_idx = paddr[lcf_pkg::CSR_ADDR_W-1:lcf_pkg::CSR_IDX_LO];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   // register write decode; unknown index is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            lcf_pkg::REG_COEF_LOW:  cfg_in.coef_word_low  = pwdata;
            lcf_pkg::REG_COEF_HIGH: cfg_in.coef_word_high = pwdata;
            lcf_pkg::REG_TAP_COUNT:
               cfg_in.tap_count = pwdata[lcf_pkg::TAP_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         lcf_pkg::REG_COEF_LOW:  prdata = cfg_ff.coef_word_low;
         lcf_pkg::REG_COEF_HIGH: prdata = cfg_ff.coef_word_high;
         lcf_pkg::REG_TAP_COUNT:
            prdata = lcf_pkg::CSR_DATA_W'(cfg_ff.tap_count);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_word_low  <= '0;
         cfg_ff.coef_word_high <= '0;
         cfg_ff.tap_count      <= lcf_pkg::TAP_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/lcf_feed.sv
// ----------------------------------------------------------------------------
// lcf_feed: sample history and tail sequencer
// Builds the tap window for each result, shifts the delay line, inserts the
// zero-fed tail after the last sample and registers the masked taps.
// ----------------------------------------------------------------------------
module lcf_feed #(
   parameter int TAPS        = lcf_pkg::TAPS_DEFAULT,
   parameter int SAMPLE_BITS = lcf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  lcf_pkg::req_type                      req_data,
   input  logic [lcf_pkg::TAP_COUNT_W-1:0]       tap_count,
   input  logic                                  mac_ready,
   output lcf_pkg::flow_type                     tap_ctl,
   output logic [TAPS-1:0][SAMPLE_BITS-1:0]      taps
);

   localparam int TailW = $clog2(TAPS);
   localparam logic [lcf_pkg::TAP_COUNT_W-1:0] TapsMax = lcf_pkg::TAP_COUNT_W'(TAPS);

   logic [TAPS-2:0][SAMPLE_BITS-1:0] hist_ff, hist_in;
   logic [TAPS-1:0][SAMPLE_BITS-1:0] taps_ff, taps_in;
   logic [TAPS-1:0][SAMPLE_BITS-1:0] window;
   lcf_pkg::flow_type                a_ctl_ff, a_ctl_in;
   logic                             flush_ff, flush_in;
   logic [TailW-1:0]                 tail_ff, tail_in;
   logic [lcf_pkg::TAP_COUNT_W-1:0]  m_use;
   logic                             ready_a;
   logic                             take;
   logic                             issue;
   logic                             issue_last;

   assign tap_ctl = a_ctl_ff;
   assign taps    = taps_ff;

   // taps in use: zero counts as one, above TAPS saturates
   always_comb begin
      priority if (tap_count == '0)
         m_use = lcf_pkg::TAP_COUNT_W'(1);
      else if (tap_count > TapsMax)
         m_use = TapsMax;
      else
         m_use = tap_count;
   end

   // handshake; tail cycles hold off new samples
   assign ready_a   = !a_ctl_ff.valid || mac_ready;
   assign req_stall = flush_ff || !ready_a;
   assign take      = req_valid && !req_stall;
   assign issue     = ready_a && (flush_ff || req_valid);

   assign issue_last = flush_ff ? (tail_ff == TailW'(1))
                                : (req_data.seq_last && (m_use == lcf_pkg::TAP_COUNT_W'(1)));

   // window: newest sample (zero during tail) then history
   always_comb begin
      window[0] = flush_ff ? '0 : SAMPLE_BITS'($unsigned(req_data.sample));
      for (int k = 1; k < TAPS; k++) begin
         window[k] = hist_ff[k-1];
      end
   end

   // mask unused taps
   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         taps_in[k] = (lcf_pkg::TAP_COUNT_W'(k) < m_use) ? window[k] : '0;
      end
   end

   // delay line: shift on each issued result, clear after the final one
   always_comb begin
      hist_in = hist_ff;
      if (issue) begin
         if (issue_last) begin
            hist_in = '0;
         end else begin
            hist_in[0] = window[0];
            for (int k = 1; k < TAPS - 1; k++) begin
               hist_in[k] = hist_ff[k-1];
            end
         end
      end
   end

   // tail sequencer
   always_comb begin
      flush_in = flush_ff;
      tail_in  = tail_ff;
      if (take && req_data.seq_last && (m_use != lcf_pkg::TAP_COUNT_W'(1))) begin
         flush_in = 1'b1;
         tail_in  = TailW'(m_use - lcf_pkg::TAP_COUNT_W'(1));
      end else if (flush_ff && issue) begin
         tail_in = tail_ff - TailW'(1);
         if (issue_last) begin
            flush_in = 1'b0;
         end
      end
   end

   // tap register control
   always_comb begin
      a_ctl_in = a_ctl_ff;
      if (ready_a) begin
         a_ctl_in.valid = issue;
         a_ctl_in.last  = issue_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         a_ctl_ff <= '0;
         flush_ff <= 1'b0;
         tail_ff  <= '0;
      end else begin
         hist_ff  <= hist_in;
         a_ctl_ff <= a_ctl_in;
         flush_ff <= flush_in;
         tail_ff  <= tail_in;
      end
   end

   // tap payload
   always_ff @(posedge clock) begin
      if (issue) begin
         taps_ff <= taps_in;
      end
   end

   // tail cycles never take a sample
   a_flush_stalls: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> req_stall)
      else $error("sample accepted during tail");

   // final result of a sequence leaves the history clear
   a_hist_cleared: assert property (@(posedge clock) disable iff (reset)
      (issue && issue_last) |=> (hist_ff == '0))
      else $error("history not cleared after sequence end");

   // tail in progress always has results left
   a_tail_nonzero: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> (tail_ff != '0))
      else $error("tail counter empty during tail");

endmodule

// File: sv/lcf_mac.sv
// ----------------------------------------------------------------------------
// lcf_mac: multiply and sum pipeline
// Registered products, registered groups of four, then the output register.
// Each stage loads whenever it is empty or the stage after it moves.
// ----------------------------------------------------------------------------
module lcf_mac #(
   parameter int TAPS        = lcf_pkg::TAPS_DEFAULT,
   parameter int SAMPLE_BITS = lcf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [lcf_pkg::CSR_DATA_W-1:0]        coef_word_low,
   input  logic [lcf_pkg::CSR_DATA_W-1:0]        coef_word_high,
   input  lcf_pkg::flow_type                     in_ctl,
   input  logic [TAPS-1:0][SAMPLE_BITS-1:0]      in_taps,
   output logic                                  in_ready,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output lcf_pkg::rsp_type                      rsp_data
);

   localparam int ResW    = lcf_pkg::RESULT_W;
   localparam int CoefW   = lcf_pkg::COEF_W;
   localparam int PerWord = lcf_pkg::COEFS_PER_WORD;
   localparam int ProdW   = SAMPLE_BITS + CoefW;
   localparam int NumGrp  = (TAPS + PerWord - 1) / PerWord;

   logic signed [CoefW-1:0]        coef [TAPS];
   logic signed [ProdW-1:0]        prod_full [TAPS];
   logic [TAPS-1:0][ResW-1:0]      prod_ff, prod_in;
   logic [NumGrp-1:0][ResW-1:0]    grp_ff, grp_in;
   logic [ResW-1:0]                res_ff, res_in;
   lcf_pkg::flow_type              b_ctl_ff, c_ctl_ff, o_ctl_ff;
   logic                           ready_b, ready_c, ready_o;

   // stage readiness, back to front
   assign ready_o  = !o_ctl_ff.valid || !rsp_stall;
   assign ready_c  = !c_ctl_ff.valid || ready_o;
   assign ready_b  = !b_ctl_ff.valid || ready_c;
   assign in_ready = ready_b;

   // coefficient unpack: four per word
   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         if (k < PerWord)
            coef[k] = coef_word_low[CoefW*(k & (PerWord-1)) +: CoefW];
         else
            coef[k] = coef_word_high[CoefW*(k & (PerWord-1)) +: CoefW];
      end
   end

   // one multiplier per tap, wrapped to result width
   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         prod_full[k] = coef[k] * $signed(in_taps[k]);
         prod_in[k]   = ResW'(prod_full[k]);
      end
   end

   // partial sums of four products
   always_comb begin
      for (int g = 0; g < NumGrp; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < TAPS; k++) begin
            if ((k >> 2) == g)
               grp_in[g] = grp_in[g] + prod_ff[k];
         end
      end
   end

   // final sum
   always_comb begin
      res_in = '0;
      for (int g = 0; g < NumGrp; g++) begin
         res_in = res_in + grp_ff[g];
      end
   end

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
         c_ctl_ff <= '0;
         o_ctl_ff <= '0;
      end else begin
         if (ready_b) b_ctl_ff <= in_ctl;
         if (ready_c) c_ctl_ff <= b_ctl_ff;
         if (ready_o) o_ctl_ff <= c_ctl_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (ready_b && in_ctl.valid)   prod_ff <= prod_in;
      if (ready_c && b_ctl_ff.valid) grp_ff  <= grp_in;
      if (ready_o && c_ctl_ff.valid) res_ff  <= res_in;
   end

   assign rsp_valid            = o_ctl_ff.valid;
   assign rsp_data.result      = $signed(res_ff);
   assign rsp_data.result_last = o_ctl_ff.last;

   // open output lets the whole pipe move
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> in_ready)
      else $error("pipe blocked while output is free");

   // blocked partial-sum stage keeps its item
   a_grp_hold: assert property (@(posedge clock) disable iff (reset)
      (c_ctl_ff.valid && !ready_o) |=> (c_ctl_ff.valid && $stable(grp_ff)))
      else $error("partial sums lost under stall");

endmodule

// File: sv/linear_convolution_fir.sv
// ----------------------------------------------------------------------------
// linear_convolution_fir: direct-form FIR, full linear convolution
// Streams signed samples through up to TAPS Q1.15 coefficients and emits one
// exact sum per sample plus (taps in use)-1 zero-fed tail results at sequence end.
//
//   port group  dir  handshake          payload
//   req_*       in   req_valid/stall    lcf_pkg::req_type (sample, seq_last)
//   rsp_*       out  rsp_valid/stall    lcf_pkg::rsp_type (result, result_last)
//   p*          in   APB write/read     64-bit registers at byte addr 8*i
//
// One result per cycle while rsp_stall is low; rsp_valid rises once the sample
// has passed the tap register (loaded at the accept edge), then the product,
// partial-sum and output registers.
// A sample with seq_last holds req_stall while the tail results are issued.
// Result stalls back up the pipe stage by stage.
// Synchronous reset empties the pipe, clears history, coefficients to zero
// and tap_count to 8.
// ----------------------------------------------------------------------------
module linear_convolution_fir #(
   parameter int TAPS        = lcf_pkg::TAPS_DEFAULT,
   parameter int SAMPLE_BITS = lcf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // input samples
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lcf_pkg::req_type                  req_data,
   // results
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lcf_pkg::rsp_type                  rsp_data,
   // configuration
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lcf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lcf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lcf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   lcf_pkg::cfg_type                  cfg;
   lcf_pkg::flow_type                 tap_ctl;
   logic [TAPS-1:0][SAMPLE_BITS-1:0]  taps;
   logic                              mac_ready;

   lcf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lcf_feed #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_feed (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .tap_count (cfg.tap_count),
      .mac_ready (mac_ready),
      .tap_ctl   (tap_ctl),
      .taps      (taps)
   );

   lcf_mac #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock          (clock),
      .reset          (reset),
      .coef_word_low  (cfg.coef_word_low),
      .coef_word_high (cfg.coef_word_high),
      .in_ctl         (tap_ctl),
      .in_taps        (taps),
      .in_ready       (mac_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

endmodule
